// File: design/assert_macros.svh
// Assertion macros shared by the color matrix RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked out of reset.
`define CCMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Non-overlapping implication: the consequent is checked in the following cycle.
`define CCMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ccmd_pkg.sv
// Package for the camera color matrix derivation block.
// Holds number formats, the fixed ProPhoto matrix, sequencer types and helpers.
package ccmd_pkg;

  localparam int COEF_FRAC_BITS = 20;
  localparam int WORK_FRAC_BITS = 32;
  localparam int COEF_W = 24;
  localparam int WORK_W = 48;
  localparam int MAG_W  = WORK_W - 1;
  localparam int IDX_W  = 4;

  localparam logic [WORK_W-1:0] WORK_MAX = {1'b0, {MAG_W{1'b1}}};
  localparam logic [WORK_W-1:0] WORK_ONE = WORK_W'(64'd1 << WORK_FRAC_BITS);

  localparam int RF_DEPTH = 36;
  localparam int RF_AW    = 6;
  localparam logic [RF_AW-1:0] C_BASE = RF_AW'(0);
  localparam logic [RF_AW-1:0] P_BASE = RF_AW'(9);
  localparam logic [RF_AW-1:0] E_BASE = RF_AW'(18);

  function automatic logic [WORK_W-1:0] ppm_to_work(longint unsigned ppm);
    longint unsigned t;
    t = ((ppm << WORK_FRAC_BITS) + 64'd500000) / 64'd1000000;
    return t[WORK_W-1:0];
  endfunction

  localparam logic [WORK_W-1:0] PRO_M [9] = '{
    ppm_to_work(529317), ppm_to_work(330092), ppm_to_work(140588),
    ppm_to_work(98368),  ppm_to_work(873465), ppm_to_work(28169),
    ppm_to_work(16879),  ppm_to_work(117663), ppm_to_work(865457)
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_OPER, ST_WAIT, ST_WB, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    PH_PROD, PH_NORM, PH_GRAM, PH_IDENT, PH_PIVOT,
    PH_PDIV, PH_FACT, PH_ELIM, PH_OUT, PH_SING
  } phase_t;

  function automatic logic [MAG_W-1:0] mag_of(logic signed [WORK_W-1:0] v);
    logic [WORK_W-1:0] m;
    m = v[WORK_W-1] ? WORK_W'(-v) : WORK_W'(v);
    return m[MAG_W-1:0];
  endfunction

  function automatic logic signed [WORK_W-1:0] sat_add(logic signed [WORK_W-1:0] a,
                                                       logic signed [WORK_W-1:0] b);
    logic signed [WORK_W:0] s;
    logic signed [WORK_W:0] lim;
    lim = $signed({1'b0, WORK_MAX});
    s = $signed({a[WORK_W-1], a}) + $signed({b[WORK_W-1], b});
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    return s[WORK_W-1:0];
  endfunction

endpackage

// File: design/camera_color_matrix_derive.sv
// Camera color matrix derivation, top level.
// Load nine camera-to-XYZ entries (in_entry_index 0..8, signed Q3.20) over
// the in_ channel. Entries 0..7 are stored when accepted; an index above
// 8 is dropped. Entry 8 starts a run: the block forms the camera-to-ProPhoto
// product, normalizes its rows, inverts the Gram matrix by Gauss-Jordan
// elimination and emits nine coefficients on the out_ channel, in
// row-major order, out_last on the ninth. out_singular marks a run that
// hit a zero row sum or pivot; its nine coefficients are then zero.
// A run performs 117 multiplies and 27 divides, all through one multiplier
// that adds one partial product per cycle and one restoring divider that
// produces one quotient bit per cycle. in_ready is low from entry 8 until
// the last coefficient is taken. A stalled receiver holds the current
// coefficient and the sequencer waits. Synchronous reset returns the
// sequencer to idle; the stored entries are not cleared.
// Depends on ccmd_pkg, ccmd_mul, ccmd_div and assert_macros.svh.
module camera_color_matrix_derive (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ccmd_pkg::IDX_W-1:0]            in_entry_index,
  input  logic signed [ccmd_pkg::COEF_W-1:0]    in_entry_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ccmd_pkg::IDX_W-1:0]            out_coef_index,
  output logic signed [ccmd_pkg::COEF_W-1:0]    out_coef_value,
  output logic                                  out_singular,
  output logic                                  out_last
);
  import ccmd_pkg::*;

  `include "assert_macros.svh"

  localparam int SH = WORK_FRAC_BITS - COEF_FRAC_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(8);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [1:0] i_r, i_nxt, k_r, k_nxt;
  logic [2:0] j_r, j_nxt;
  logic [IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic sing_r, sing_nxt;
  logic signed [WORK_W-1:0] acc_r, acc_nxt, sum_r, sum_nxt;
  logic signed [WORK_W-1:0] piv_r, piv_nxt, f_r, f_nxt, res_r, res_nxt;

  logic signed [WORK_W-1:0] rf_mem [RF_DEPTH];
  logic signed [WORK_W-1:0] rd_a_r, rd_b_r;
  logic [RF_AW-1:0] raddr_a, raddr_b, waddr;
  logic signed [WORK_W-1:0] wdata;
  logic we;

  logic mul_start, mul_done, div_start, div_done;
  logic signed [WORK_W-1:0] mul_b, mul_res, div_den, div_res;
  logic signed [WORK_W-1:0] acc_sum, sum_new, elim_val;
  logic [2:0] kn;
  logic in_acc, out_acc;
  logic is_mul_ph, is_div_ph;
  logic [MAG_W-1:0] out_mag;
  logic [MAG_W-SH:0] out_rnd;
  logic [COEF_W-1:0] out_sat;

  function automatic logic [RF_AW-1:0] a3(logic [RF_AW-1:0] base, logic [1:0] r,
                                          logic [2:0] c);
    return base + RF_AW'(r) * RF_AW'(3) + RF_AW'(c);
  endfunction

  function automatic logic [RF_AW-1:0] a6(logic [RF_AW-1:0] base, logic [1:0] r,
                                          logic [2:0] c);
    return base + RF_AW'(r) * RF_AW'(6) + RF_AW'(c);
  endfunction

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  assign is_mul_ph = (phase_r == PH_PROD) || (phase_r == PH_GRAM) ||
                     (phase_r == PH_ELIM) || (phase_r == PH_OUT);
  assign is_div_ph = (phase_r == PH_NORM) || (phase_r == PH_PDIV);

  // read address decode
  always_comb begin
    raddr_a = C_BASE;
    raddr_b = C_BASE;
    unique case (phase_r)
      PH_PROD:  raddr_a = a3(C_BASE, i_r, 3'(k_r));
      PH_NORM:  raddr_a = a3(P_BASE, i_r, j_r);
      PH_GRAM: begin
        raddr_a = a3(P_BASE, k_r, 3'(i_r));
        raddr_b = a3(P_BASE, k_r, j_r);
      end
      PH_PIVOT: raddr_a = a6(E_BASE, i_r, 3'(i_r));
      PH_PDIV:  raddr_a = a6(E_BASE, i_r, j_r);
      PH_FACT:  raddr_a = a6(E_BASE, k_r, 3'(i_r));
      PH_ELIM: begin
        raddr_a = a6(E_BASE, i_r, j_r);
        raddr_b = a6(E_BASE, k_r, j_r);
      end
      PH_OUT: begin
        raddr_a = a6(E_BASE, j_r[1:0], 3'(k_r) + 3'd3);
        raddr_b = a3(P_BASE, i_r, 3'(k_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) rf_mem[waddr] <= wdata;
    rd_a_r <= rf_mem[raddr_a];
    rd_b_r <= rf_mem[raddr_b];
  end

  always_comb begin
    case (phase_r)
      PH_PROD: mul_b = $signed(PRO_M[4'(a3(C_BASE, k_r, j_r))]);
      PH_ELIM: mul_b = f_r;
      default: mul_b = rd_b_r;
    endcase
    div_den   = (phase_r == PH_NORM) ? sum_r : piv_r;
    mul_start = (state_r == ST_OPER) && is_mul_ph;
    div_start = (state_r == ST_OPER) && is_div_ph;
    acc_sum   = sat_add(acc_r, mul_res);
    sum_new   = sat_add(sum_r, acc_sum);
    elim_val  = sat_add(rd_b_r, -mul_res);
    kn = 3'(k_r) + 3'd1;
    if (kn[1:0] == i_r && kn < 3'd3) kn = kn + 3'd1;
  end

  ccmd_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (rd_a_r),
    .op_b   (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  ccmd_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (rd_a_r),
    .den    (div_den),
    .done   (div_done),
    .result (div_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_entry_index == LAST_IDX) state_nxt = ST_ISSUE;
      ST_ISSUE: begin
        if (phase_r == PH_IDENT)     state_nxt = ST_WB;
        else if (phase_r == PH_SING) state_nxt = ST_EMIT;
        else                         state_nxt = ST_OPER;
      end
      ST_OPER:  state_nxt = (is_mul_ph || is_div_ph) ? ST_WAIT : ST_ISSUE;
      ST_WAIT:  if (mul_done || div_done) state_nxt = ST_WB;
      ST_WB:    state_nxt = (phase_r == PH_OUT && k_r == 2'd2) ? ST_EMIT : ST_ISSUE;
      ST_EMIT: begin
        if (out_ready) begin
          if (o_idx_r == LAST_IDX) state_nxt = ST_IDLE;
          else if (sing_r)         state_nxt = ST_EMIT;
          else                     state_nxt = ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer counters and datapath
  always_comb begin
    phase_nxt = phase_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    o_idx_nxt = o_idx_r;
    sing_nxt = sing_r;
    acc_nxt = acc_r;
    sum_nxt = sum_r;
    piv_nxt = piv_r;
    f_nxt = f_r;
    res_nxt = res_r;
    we = 1'b0;
    waddr = a3(P_BASE, i_r, j_r);
    wdata = mul_res;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_entry_index <= LAST_IDX) begin
          we    = 1'b1;
          waddr = RF_AW'(in_entry_index);
          wdata = WORK_W'(in_entry_value) <<< SH;
          if (in_entry_index == LAST_IDX) begin
            phase_nxt = PH_PROD;
            i_nxt = '0;
            j_nxt = '0;
            k_nxt = '0;
            acc_nxt = '0;
            sum_nxt = '0;
            sing_nxt = 1'b0;
            o_idx_nxt = '0;
          end
        end
      end
      ST_OPER: begin
        if (phase_r == PH_PIVOT) begin
          if (rd_a_r == '0) begin
            sing_nxt = 1'b1;
            phase_nxt = PH_SING;
          end else begin
            piv_nxt = rd_a_r;
            phase_nxt = PH_PDIV;
            j_nxt = '0;
          end
        end else if (phase_r == PH_FACT) begin
          f_nxt = rd_a_r;
          phase_nxt = PH_ELIM;
          j_nxt = '0;
        end
      end
      ST_WB: begin
        unique case (phase_r)
          PH_PROD: begin
            if (k_r != 2'd2) begin
              acc_nxt = acc_sum;
              k_nxt = k_r + 2'd1;
            end else begin
              we = 1'b1;
              wdata = acc_sum;
              sum_nxt = sum_new;
              acc_nxt = '0;
              k_nxt = '0;
              if (j_r != 3'd2) begin
                j_nxt = j_r + 3'd1;
              end else if (sum_new == '0) begin
                sing_nxt = 1'b1;
                phase_nxt = PH_SING;
              end else begin
                phase_nxt = PH_NORM;
                j_nxt = '0;
              end
            end
          end
          PH_NORM: begin
            we = 1'b1;
            wdata = div_res;
            if (j_r != 3'd2) begin
              j_nxt = j_r + 3'd1;
            end else begin
              j_nxt = '0;
              if (i_r != 2'd2) begin
                i_nxt = i_r + 2'd1;
                sum_nxt = '0;
                phase_nxt = PH_PROD;
              end else begin
                i_nxt = '0;
                k_nxt = '0;
                phase_nxt = PH_GRAM;
              end
            end
          end
          PH_GRAM: begin
            if (k_r != 2'd2) begin
              acc_nxt = acc_sum;
              k_nxt = k_r + 2'd1;
            end else begin
              we = 1'b1;
              waddr = a6(E_BASE, i_r, j_r);
              wdata = acc_sum;
              acc_nxt = '0;
              k_nxt = '0;
              if (j_r != 3'd2) begin
                j_nxt = j_r + 3'd1;
              end else begin
                j_nxt = '0;
                if (i_r != 2'd2) begin
                  i_nxt = i_r + 2'd1;
                end else begin
                  i_nxt = '0;
                  phase_nxt = PH_IDENT;
                end
              end
            end
          end
          PH_IDENT: begin
            we = 1'b1;
            waddr = a6(E_BASE, i_r, j_r + 3'd3);
            wdata = (3'(i_r) == j_r) ? $signed(WORK_ONE) : '0;
            if (j_r != 3'd2) begin
              j_nxt = j_r + 3'd1;
            end else begin
              j_nxt = '0;
              if (i_r != 2'd2) begin
                i_nxt = i_r + 2'd1;
              end else begin
                i_nxt = '0;
                phase_nxt = PH_PIVOT;
              end
            end
          end
          PH_PDIV: begin
            we = 1'b1;
            waddr = a6(E_BASE, i_r, j_r);
            wdata = div_res;
            if (j_r != 3'd5) begin
              j_nxt = j_r + 3'd1;
            end else begin
              k_nxt = (i_r == 2'd0) ? 2'd1 : 2'd0;
              phase_nxt = PH_FACT;
            end
          end
          PH_ELIM: begin
            we = 1'b1;
            waddr = a6(E_BASE, k_r, j_r);
            wdata = elim_val;
            if (j_r != 3'd5) begin
              j_nxt = j_r + 3'd1;
            end else begin
              j_nxt = '0;
              if (kn < 3'd3) begin
                k_nxt = kn[1:0];
                phase_nxt = PH_FACT;
              end else if (i_r != 2'd2) begin
                i_nxt = i_r + 2'd1;
                phase_nxt = PH_PIVOT;
              end else begin
                i_nxt = '0;
                k_nxt = '0;
                acc_nxt = '0;
                phase_nxt = PH_OUT;
              end
            end
          end
          PH_OUT: begin
            if (k_r != 2'd2) begin
              acc_nxt = acc_sum;
              k_nxt = k_r + 2'd1;
            end else begin
              res_nxt = acc_sum;
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (out_ready) begin
          o_idx_nxt = o_idx_r + IDX_W'(1);
          if (!sing_r && o_idx_r != LAST_IDX) begin
            acc_nxt = '0;
            k_nxt = '0;
            if (j_r != 3'd2) begin
              j_nxt = j_r + 3'd1;
            end else begin
              j_nxt = '0;
              i_nxt = i_r + 2'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_PROD;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      o_idx_r <= '0;
      sing_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      o_idx_r <= o_idx_nxt;
      sing_r <= sing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sum_r <= sum_nxt;
    piv_r <= piv_nxt;
    f_r   <= f_nxt;
    res_r <= res_nxt;
  end

  // round the work value to coefficient format (ties away from zero) and saturate
  always_comb begin
    out_mag = mag_of(res_r);
    out_rnd = (MAG_W-SH+1)'((MAG_W+1)'(out_mag) + (MAG_W+1)'(64'd1 << (SH - 1)) >> SH);
    out_sat = (out_rnd > (MAG_W-SH+1)'({1'b0, {(COEF_W-1){1'b1}}}))
              ? {1'b0, {(COEF_W-1){1'b1}}} : COEF_W'(out_rnd);
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_EMIT);
  assign out_coef_index = o_idx_r;
  assign out_singular   = sing_r;
  assign out_last       = (o_idx_r == LAST_IDX);
  assign out_coef_value = sing_r ? '0
                        : (res_r[WORK_W-1] ? -$signed(out_sat) : $signed(out_sat));

  `CCMD_ASSERT_IMP(a_one_run, out_valid, !in_ready, "input taken during a run")
  `CCMD_ASSERT_IMP(a_sing_zero, out_valid && out_singular, out_coef_value == '0,
                   "singular run emitted a nonzero coefficient")
  `CCMD_ASSERT_NXT(a_last_idle, out_valid && out_ready && out_last, in_ready,
                   "block not idle after last coefficient")
  `CCMD_ASSERT_IMP(a_one_unit, mul_start, !div_start, "both arithmetic units started")

endmodule

// File: design/ccmd_mul.sv
// Shared multiplier: signed work-format product, rounded and saturated.
// Four 24x24 partial products, one per cycle; depends on ccmd_pkg.
module ccmd_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [ccmd_pkg::WORK_W-1:0]    op_a,
  input  logic signed [ccmd_pkg::WORK_W-1:0]    op_b,
  output logic                                  done,
  output logic signed [ccmd_pkg::WORK_W-1:0]    result
);
  import ccmd_pkg::*;

  localparam int H = 24;
  localparam int PW = 2 * MAG_W;

  logic [MAG_W-1:0]  ma_r, mb_r;
  logic              neg_r;
  logic [PW-1:0]     acc_r;
  logic [2:0]        cnt_r;
  logic              busy_r, done_r;
  logic signed [WORK_W-1:0] res_r;

  logic [H-1:0]      a_sel, b_sel;
  logic [2*H-1:0]    pp;
  logic [PW-1:0]     pp_sh;
  logic [PW:0]       rnd;
  logic [PW-WORK_FRAC_BITS:0] q;
  logic [WORK_W-1:0] qs;

  always_comb begin
    a_sel = cnt_r[1] ? H'(ma_r[MAG_W-1:H]) : ma_r[H-1:0];
    b_sel = cnt_r[0] ? H'(mb_r[MAG_W-1:H]) : mb_r[H-1:0];
    pp    = a_sel * b_sel;
    case (cnt_r[1:0])
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << (2 * H);
      default: pp_sh = PW'(pp) << H;
    endcase
    rnd = {1'b0, acc_r} + (PW+1)'(64'd1 << (WORK_FRAC_BITS - 1));
    q   = rnd[PW:WORK_FRAC_BITS];
    qs  = (q > (PW-WORK_FRAC_BITS+1)'(WORK_MAX)) ? WORK_MAX : WORK_W'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= mag_of(op_a);
      mb_r  <= mag_of(op_b);
      neg_r <= op_a[WORK_W-1] ^ op_b[WORK_W-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == 3'd4) begin
        res_r <= neg_r ? -$signed(qs) : $signed(qs);
      end else begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// File: design/ccmd_div.sv
// Shared divider: signed work-format quotient, rounded and saturated.
// Restoring division, one quotient bit per cycle; depends on ccmd_pkg.
module ccmd_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [ccmd_pkg::WORK_W-1:0]    num,
  input  logic signed [ccmd_pkg::WORK_W-1:0]    den,
  output logic                                  done,
  output logic signed [ccmd_pkg::WORK_W-1:0]    result
);
  import ccmd_pkg::*;

  localparam int NW = MAG_W + WORK_FRAC_BITS;

  logic [NW-1:0]     num_r;
  logic [MAG_W-1:0]  ub_r;
  logic [WORK_W-1:0] rem_r;
  logic [WORK_W-1:0] q_r;
  logic [6:0]        pos_r;
  logic              neg_r, over_r, busy_r, fin_r, done_r;
  logic signed [WORK_W-1:0] res_r;

  logic [WORK_W:0]   r2;
  logic              ge;
  logic              rnd_up;
  logic [WORK_W:0]   qf;
  logic [WORK_W-1:0] qm;

  always_comb begin
    r2     = {rem_r, num_r[NW-1]};
    ge     = r2 >= (WORK_W+1)'(ub_r);
    rnd_up = {rem_r, 1'b0} >= (WORK_W+1)'(ub_r);
    qf     = (WORK_W+1)'(q_r) + (WORK_W+1)'(rnd_up);
    qm     = (over_r || qf > (WORK_W+1)'(WORK_MAX)) ? WORK_MAX : qf[WORK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && pos_r == '0) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
      if (fin_r) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= {mag_of(num), {WORK_FRAC_BITS{1'b0}}};
      ub_r   <= mag_of(den);
      neg_r  <= num[WORK_W-1] ^ den[WORK_W-1];
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
      pos_r  <= 7'(NW - 1);
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= ge ? WORK_W'(r2 - (WORK_W+1)'(ub_r)) : r2[WORK_W-1:0];
      q_r   <= {q_r[WORK_W-2:0], ge && (pos_r < 7'(MAG_W))};
      if (ge && pos_r >= 7'(MAG_W)) over_r <= 1'b1;
      pos_r <= pos_r - 7'd1;
    end else if (fin_r) begin
      res_r <= neg_r ? -$signed(qm) : $signed(qm);
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// File: sim/ccmd_checker.sv
// Checker for camera_color_matrix_derive: watches both channels, predicts the
// nine coefficients of each run and compares them in order.
// Depends on ccmd_pkg for field widths.
module ccmd_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [ccmd_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [ccmd_pkg::COEF_W-1:0] in_entry_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [ccmd_pkg::IDX_W-1:0]         out_coef_index,
  input  logic signed [ccmd_pkg::COEF_W-1:0] out_coef_value,
  input  logic                               out_singular,
  input  logic                               out_last,
  output int                                 fail_count,
  output int                                 coefs_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ccmd_pkg::*;

  localparam longint W_MAX = 64'h7FFF_FFFF_FFFF;
  localparam longint C_MAX = 64'h7F_FFFF;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] value;
    logic                     singular;
    logic                     last;
  } coef_t;

  coef_t  coef_due[$];
  longint cam[9];
  longint prophoto[9];

  function automatic longint clamp_w(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint add_w(longint a, longint b);
    return clamp_w(a + b, W_MAX);
  endfunction

  function automatic longint mul_w(longint a, longint b);
    logic [127:0] p;
    longint unsigned ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (128'(ma) * 128'(mb) + (128'd1 << (WORK_FRAC_BITS - 1))) >> WORK_FRAC_BITS;
    if (p > 128'(W_MAX)) p = 128'(W_MAX);
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint div_w(longint a, longint b);
    logic [127:0] num, q, r;
    longint unsigned ua, ub;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    num = 128'(ua) << WORK_FRAC_BITS;
    q = num / 128'(ub);
    r = num % 128'(ub);
    if (q >= (128'd1 << 47)) begin
      q = 128'(W_MAX);
    end else begin
      if (2 * r >= 128'(ub)) q = q + 1;
      if (q > 128'(W_MAX)) q = 128'(W_MAX);
    end
    return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Run the whole derivation; return 0 on a zero row sum or pivot.
  function automatic bit derive_coefs(output longint res[9]);
    longint c[9], p[9], e[3][6];
    longint acc, sum, piv, f;
    for (int i = 0; i < 9; i++) c[i] = cam[i] <<< (WORK_FRAC_BITS - COEF_FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc = add_w(acc, mul_w(c[i*3+k], prophoto[k*3+j]));
        p[i*3+j] = acc;
        sum = add_w(sum, acc);
      end
      if (sum == 0) return 0;
      for (int j = 0; j < 3; j++) p[i*3+j] = div_w(p[i*3+j], sum);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc = add_w(acc, mul_w(p[k*3+i], p[k*3+j]));
        e[i][j] = acc;
        e[i][j+3] = (i == j) ? (64'd1 << WORK_FRAC_BITS) : 0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      piv = e[i][i];
      if (piv == 0) return 0;
      for (int j = 0; j < 6; j++) e[i][j] = div_w(e[i][j], piv);
      for (int k = 0; k < 3; k++) begin
        if (k != i) begin
          f = e[k][i];
          for (int j = 0; j < 6; j++) e[k][j] = add_w(e[k][j], -mul_w(e[i][j], f));
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc = add_w(acc, mul_w(e[j][k+3], p[i*3+k]));
        // round to coefficient format, ties away from zero
        sum = acc < 0 ? -acc : acc;
        sum = (sum + (64'd1 << (WORK_FRAC_BITS - COEF_FRAC_BITS - 1)))
              >> (WORK_FRAC_BITS - COEF_FRAC_BITS);
        if (sum > C_MAX) sum = C_MAX;
        res[i*3+j] = acc < 0 ? -sum : sum;
      end
    end
    return 1;
  endfunction

  initial begin
    fail_count = 0;
    for (int i = 0; i < 9; i++) begin
      cam[i] = 0;
      prophoto[i] = 0;
    end
    prophoto[0] = 529317; prophoto[1] = 330092; prophoto[2] = 140588;
    prophoto[3] = 98368;  prophoto[4] = 873465; prophoto[5] = 28169;
    prophoto[6] = 16879;  prophoto[7] = 117663; prophoto[8] = 865457;
    for (int i = 0; i < 9; i++)
      prophoto[i] = ((prophoto[i] <<< WORK_FRAC_BITS) + 500000) / 1000000;
  end

  assign coefs_pending = coef_due.size();

  always @(posedge clk) begin
    longint res[9];
    bit     ok;
    coef_t  c;
    if (rst_n && in_valid && in_ready && in_entry_index <= 8) begin
      cam[in_entry_index] = longint'(in_entry_value);
      if (in_entry_index == 8) begin
        ok = derive_coefs(res);
        for (int k = 0; k < 9; k++) begin
          c.idx = IDX_W'(k);
          c.value = ok ? COEF_W'(res[k]) : '0;
          c.singular = !ok;
          c.last = (k == 8);
          coef_due.push_back(c);
        end
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (coef_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected coefficient transaction: index %0d value %0d",
                   out_coef_index, out_coef_value);
      end else begin
        c = coef_due.pop_front();
        if (out_coef_index !== c.idx || out_coef_value !== c.value ||
            out_singular !== c.singular || out_last !== c.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("coef mismatch: exp idx %0d val %0d sing %0b last %0b, got %0d %0d %0b %0b",
                     c.idx, c.value, c.singular, c.last,
                     out_coef_index, out_coef_value, out_singular, out_last);
        end
      end
    end
  end

endmodule

// File: sim/tb_camera_color_matrix_derive.sv
// Testbench top for camera_color_matrix_derive: clock, reset, entry stimulus,
// receiver stalls and the verdict. Depends on ccmd_pkg and ccmd_checker.
module tb_camera_color_matrix_derive;
  timeunit 1ns;
  timeprecision 1ps;
  import ccmd_pkg::*;

  localparam logic signed [COEF_W-1:0] V_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] V_MIN = 24'sh800000;
  localparam logic signed [COEF_W-1:0] V_ONE = 24'sh100000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic signed [COEF_W-1:0] in_entry_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_coef_index;
  logic signed [COEF_W-1:0] out_coef_value;
  logic out_singular;
  logic out_last;
  int fail_count;
  int coefs_pending;
  int entries_sent = 0;
  bit send_calm = 0;

  always #6 clk = ~clk;

  camera_color_matrix_derive i_dut (.*);

  ccmd_checker i_checker (.*);

  task automatic send_entry(input int idx, input logic signed [COEF_W-1:0] val);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_entry_index <= IDX_W'(idx);
    in_entry_value <= val;
    do @(posedge clk); while (!in_ready);
    entries_sent++;
  endtask

  function automatic logic signed [COEF_W-1:0] draw_entry(int kind, int idx);
    case (kind)
      0: return COEF_W'($urandom);
      1: return COEF_W'(((idx % 4 == 0) ? int'(V_ONE) : 0)
                        + int'($urandom_range(0, 1 << 19)) - (1 << 18));
      default: begin
        case ($urandom_range(0, 4))
          0: return V_MAX;
          1: return V_MIN;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Load rows of entries (entry 8 last, which starts the run).
  task automatic send_matrix(input logic signed [COEF_W-1:0] m[9]);
    for (int i = 0; i < 9; i++) send_entry(i, m[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (coefs_pending != 0);
  endtask

  // receiver: per-transaction stall, one long hold-off, calm runs
  initial begin
    int gap, taken;
    bit calm;
    taken = 0;
    calm = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (taken % 9 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 16);
      if (taken == 90) gap = 3000;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic signed [COEF_W-1:0] m[9];
    int kind;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity camera matrix, with out-of-range indexes dropped in between
    m = '{V_ONE, 0, 0, 0, V_ONE, 0, 0, 0, V_ONE};
    for (int i = 0; i < 8; i++) send_entry(i, m[i]);
    send_entry(9, V_MAX);
    send_entry(15, V_MIN);
    send_entry(8, m[8]);
    // field extremes
    m = '{V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, 0, 1, -1, V_MAX};
    send_matrix(m);
    // zero first row: zero row sum
    send_entry(0, 0);
    send_entry(1, 0);
    send_entry(2, 0);
    send_entry(8, V_ONE);
    wait_drained();

    while (entries_sent < 480) begin
      send_calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        for (int i = 0; i < 9; i++) m[i] = draw_entry(kind % 3, i);
        if ($urandom_range(0, 5) == 0) begin
          // partial update: only some entries change before the run
          for (int i = 0; i < 8; i++)
            if ($urandom_range(0, 1)) send_entry(i, m[i]);
          send_entry(8, m[8]);
        end else begin
          for (int i = 0; i < 8; i++) begin
            send_entry(i, m[i]);
            if ($urandom_range(0, 15) == 0) send_entry($urandom_range(9, 15), draw_entry(0, 0));
          end
          send_entry(8, m[8]);
        end
      end else if (kind == 7) begin
        // zero row, any of the three rows
        kind = $urandom_range(0, 2);
        for (int j = 0; j < 3; j++) send_entry(kind * 3 + j, 0);
        send_entry(8, (kind == 2) ? 24'sd0 : draw_entry(1, 8));
      end else if (kind == 8) begin
        send_entry($urandom_range(0, 7), draw_entry($urandom_range(0, 2), 0));
      end else begin
        send_entry($urandom_range(9, 15), draw_entry(0, 0));
      end
      if (entries_sent > 240 && entries_sent < 260) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
